FILE: design/yuyv2rgb_pkg.sv
// Package for the YUYV to scaled RGB888 converter: payload structs,
// fixed-point color coefficients and the clamp/scale helpers.
// No dependencies.
`default_nettype none

package yuyv2rgb_pkg;

  // Coefficients, signed, 16 fraction bits
  localparam logic signed [17:0] COEF_RV = 18'sd89831;
  localparam logic signed [17:0] COEF_GV = 18'sd45744;
  localparam logic signed [17:0] COEF_GU = 18'sd22127;
  localparam logic signed [17:0] COEF_BU = 18'sd113538;

  localparam int          FRAC_BITS = 16;
  localparam int          SUM_W     = 27;   // Y<<16 plus largest chroma term, signed
  localparam int          GAIN_W    = 9;
  localparam logic [8:0]  GAIN_RESET = 9'd220;
  localparam logic [7:0]  CHAN_MAX  = 8'd255;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_u;
    logic [7:0] luma_second;
    logic [7:0] chroma_v;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Truncate toward zero, clamp to 0..255
  function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
    logic [7:0] res;
    if (sum[SUM_W-1]) begin
      res = 8'd0;
    end else if (|sum[SUM_W-2:FRAC_BITS+8]) begin
      res = CHAN_MAX;
    end else begin
      res = sum[FRAC_BITS+7:FRAC_BITS];
    end
    return res;
  endfunction

  // (whole * gain) >> 8, saturating at 255
  function automatic logic [7:0] scale_channel(input logic [7:0]        whole,
                                               input logic [GAIN_W-1:0] gain);
    logic [16:0] prod;
    logic [8:0]  quo;
    prod = whole * gain;
    quo  = prod[16:8];
    return quo[8] ? CHAN_MAX : quo[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/yuyv2rgb_chan_mix.sv
// One pixel of the color matrix: Y plus chroma terms, truncated and clamped.
// Uses yuyv2rgb_pkg. Purely combinational.
`default_nettype none

module yuyv2rgb_chan_mix (
  input  wire logic [7:0]        luma,
  input  wire logic [7:0]        chroma_u,
  input  wire logic [7:0]        chroma_v,
  output      yuyv2rgb_pkg::rgb_t pix
);
  import yuyv2rgb_pkg::*;

  logic signed [7:0]       du;
  logic signed [7:0]       dv;
  logic signed [25:0]      prod_rv;
  logic signed [25:0]      prod_gv;
  logic signed [25:0]      prod_gu;
  logic signed [25:0]      prod_bu;
  logic signed [SUM_W-1:0] y_fx;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_b;

  // x - 128 as 8-bit two's complement is x with the top bit flipped
  assign du = {~chroma_u[7], chroma_u[6:0]};
  assign dv = {~chroma_v[7], chroma_v[6:0]};

  assign prod_rv = COEF_RV * dv;
  assign prod_gv = COEF_GV * dv;
  assign prod_gu = COEF_GU * du;
  assign prod_bu = COEF_BU * du;

  assign y_fx  = $signed({3'b000, luma, 16'h0000});
  assign sum_r = y_fx + SUM_W'(prod_rv);
  assign sum_g = y_fx - SUM_W'(prod_gv) - SUM_W'(prod_gu);
  assign sum_b = y_fx + SUM_W'(prod_bu);

  assign pix.red   = clamp_channel(sum_r);
  assign pix.green = clamp_channel(sum_g);
  assign pix.blue  = clamp_channel(sum_b);

endmodule

`default_nettype wire

FILE: design/yuyv_to_rgb_scaled_converter.sv
// Top level of the YUYV macropixel to scaled RGB888 converter.
// Uses yuyv2rgb_pkg and yuyv2rgb_chan_mix (one instance per pixel).
//
//   channel | ports                          | one transaction
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data    | one YUYV macropixel + frame end
//   result  | out_valid, out_stall, out_data | two scaled RGB888 pixels
//   config  | cfg_wr_en, cfg_wr_data         | output_gain write
//
// Two register stages: input capture and scaled result. Color matrix, clamp
// and gain multiply all sit between them in one combinational pass.
// One transaction per cycle sustained while out_stall is low; an accepted item
// passes the capture register, then the result register. Each stage advances
// when it is empty or the stage after it moves, so in_stall rises only when
// both stages are full and out_stall is high. Synchronous active-low reset
// empties the pipe, gain goes to 220.
`default_nettype none

module yuyv_to_rgb_scaled_converter (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output      logic                    in_stall,
  input  wire yuyv2rgb_pkg::in_item_t  in_data,
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      yuyv2rgb_pkg::out_item_t out_data,
  input  wire logic                    cfg_wr_en,
  input  wire logic [8:0]              cfg_wr_data
);
  import yuyv2rgb_pkg::*;

  logic [GAIN_W-1:0] gain_r;

  // stage 1: captured input
  logic     s1_valid_r;
  in_item_t s1_item_r;
  // stage 2: result register
  logic      s2_valid_r;
  out_item_t s2_item_r;
  out_item_t s2_item_nxt;

  logic s1_ready;
  logic s2_ready;

  rgb_t mix_first;
  rgb_t mix_second;

  assign s2_ready = !s2_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;

  assign in_stall  = !s1_ready;
  assign out_valid = s2_valid_r;
  assign out_data  = s2_item_r;

  yuyv2rgb_chan_mix u_mix_first (
    .luma     (s1_item_r.luma_first),
    .chroma_u (s1_item_r.chroma_u),
    .chroma_v (s1_item_r.chroma_v),
    .pix      (mix_first)
  );

  yuyv2rgb_chan_mix u_mix_second (
    .luma     (s1_item_r.luma_second),
    .chroma_u (s1_item_r.chroma_u),
    .chroma_v (s1_item_r.chroma_v),
    .pix      (mix_second)
  );

  // gain applied on the way into the result register
  always_comb begin
    s2_item_nxt.red_first    = scale_channel(mix_first.red,    gain_r);
    s2_item_nxt.green_first  = scale_channel(mix_first.green,  gain_r);
    s2_item_nxt.blue_first   = scale_channel(mix_first.blue,   gain_r);
    s2_item_nxt.red_second   = scale_channel(mix_second.red,   gain_r);
    s2_item_nxt.green_second = scale_channel(mix_second.green, gain_r);
    s2_item_nxt.blue_second  = scale_channel(mix_second.blue,  gain_r);
    s2_item_nxt.frame_last   = s1_item_r.end_of_frame;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= GAIN_RESET;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_item_r <= in_data;
    end
    if (s1_valid_r && s2_ready) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // input backs up only when both stages are full and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (s1_valid_r && s2_valid_r && out_stall))
    else $error("in_stall does not match pipeline occupancy");

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // with gain at most unity a scaled channel never exceeds its clamped value
  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready && gain_r <= 9'd256)
      |=> (s2_item_r.red_first <= $past(mix_first.red)) &&
          (s2_item_r.blue_second <= $past(mix_second.blue)))
    else $error("scaled channel exceeds clamped value at unity gain or less");

  // frame end mark carried from capture to result
  a_eof_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready) |=> s2_item_r.frame_last == $past(s1_item_r.end_of_frame))
    else $error("frame end mark lost");

endmodule

`default_nettype wire

FILE: dv/tb_yuyv_to_rgb_scaled_converter.sv
// Testbench for yuyv_to_rgb_scaled_converter: a fixed-point color model
// predicts every RGB pair, a result monitor checks each output transaction.
// Depends on yuyv2rgb_pkg (payload structs) and the converter RTL.
module tb_yuyv_to_rgb_scaled_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import yuyv2rgb_pkg::*;

  // BT.601-style coefficients, signed, 16 fraction bits
  localparam longint RV_FACTOR = 89831;
  localparam longint GV_FACTOR = 45744;
  localparam longint GU_FACTOR = 22127;
  localparam longint BU_FACTOR = 113538;
  localparam longint CHROMA_BIAS = 128;

  localparam logic [8:0] GAIN_AT_RESET = 9'd220;
  localparam int MAX_WAIT    = 17;    // longest random gap or stall per transaction
  localparam int HOLD_CYCLES = 150;   // long receiver hold-off for the fill-up test
  localparam int QUIET_LIMIT = 2000;  // cycles without any transaction before giving up
  localparam int PIPE_DEPTH  = 2;     // register stages from capture to result

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_wr_en;
  logic [8:0] cfg_wr_data;

  // Shared state between the stimulus, the sink and the monitor
  out_item_t   pending_rgb[$];     // expected results, oldest first
  logic [8:0]  gain_now;           // gain the converter holds right now
  bit          src_gaps;           // sender inserts random idle cycles
  bit          sink_gaps;          // receiver inserts random stall cycles
  int unsigned sink_hold;          // one-shot long hold-off request for the receiver
  int unsigned macropixels_sent;
  int unsigned rgb_checked;
  int unsigned gains_applied;
  int unsigned frames_sent;
  int unsigned fail_count;
  int unsigned quiet_cycles;

  yuyv_to_rgb_scaled_converter i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Color model
  // ---------------------------------------------------------------------------

  // Truncate toward zero, clamp to 0..255, then scale by gain/256 with saturation.
  function automatic logic [7:0] grade_channel(input longint acc, input logic [8:0] gain);
    longint whole;
    longint scaled;
    if (acc < 0) return 8'd0;
    whole = acc >>> 16;
    if (whole > 255) whole = 255;
    scaled = (whole * longint'(gain)) >>> 8;
    return (scaled > 255) ? 8'd255 : scaled[7:0];
  endfunction

  function automatic out_item_t rgb_from_yuyv(input in_item_t px, input logic [8:0] gain);
    out_item_t rgb;
    longint    du;
    longint    dv;
    longint    y0;
    longint    y1;
    du = longint'(px.chroma_u) - CHROMA_BIAS;
    dv = longint'(px.chroma_v) - CHROMA_BIAS;
    y0 = longint'(px.luma_first) <<< 16;
    y1 = longint'(px.luma_second) <<< 16;
    rgb.red_first    = grade_channel(y0 + RV_FACTOR * dv, gain);
    rgb.green_first  = grade_channel(y0 - GV_FACTOR * dv - GU_FACTOR * du, gain);
    rgb.blue_first   = grade_channel(y0 + BU_FACTOR * du, gain);
    rgb.red_second   = grade_channel(y1 + RV_FACTOR * dv, gain);
    rgb.green_second = grade_channel(y1 - GV_FACTOR * dv - GU_FACTOR * du, gain);
    rgb.blue_second  = grade_channel(y1 + BU_FACTOR * du, gain);
    rgb.frame_last   = px.end_of_frame;
    return rgb;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t yuyv(input logic [7:0] y0, input logic [7:0] u,
                                    input logic [7:0] y1, input logic [7:0] v,
                                    input logic eof);
    in_item_t px;
    px.luma_first   = y0;
    px.chroma_u     = u;
    px.luma_second  = y1;
    px.chroma_v     = v;
    px.end_of_frame = eof;
    return px;
  endfunction

  // Mostly uniform bytes; some near-gray chroma and rail luma to hit clamp edges.
  function automatic in_item_t random_macropixel(input logic eof);
    in_item_t    px;
    int unsigned pick;
    px   = yuyv(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), eof);
    pick = $urandom_range(99, 0);
    if (pick < 10) begin
      px.chroma_u = 8'($urandom_range(136, 120));
      px.chroma_v = 8'($urandom_range(136, 120));
    end else if (pick < 20) begin
      px.luma_first  = $urandom_range(1, 0) ? 8'd255 : 8'd0;
      px.luma_second = $urandom_range(1, 0) ? 8'd255 : 8'd0;
    end
    return px;
  endfunction

  // One input transaction. Valid stays up between back-to-back sends and is
  // only dropped for a drawn gap, so the line never toggles twice in a step.
  task automatic send_macropixel(input in_item_t px);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(MAX_WAIT, 0) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (in_stall);
    macropixels_sent++;
    pending_rgb.push_back(rgb_from_yuyv(px, gain_now));
  endtask

  // Stop offering and wait until every expected result is back, plus the pipe.
  task automatic drain_pipe();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rgb.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // Gain is only changed while the converter is empty.
  task automatic write_gain(input logic [8:0] gain);
    drain_pipe();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = gain;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    gain_now  = gain;
    gains_applied++;
  endtask

  // Gains above 256 are legal register values; most draws stay in 0..256.
  function automatic logic [8:0] random_gain();
    return ($urandom_range(3, 0) == 0) ? 9'($urandom_range(511, 257))
                                       : 9'($urandom_range(256, 0));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Rails, gray axis, bit patterns and clamp corners at the reset gain,
  // then full-white and mid-gray through the gain extremes.
  task automatic test_directed_corners();
    in_item_t corners[$];
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    corners = '{
      yuyv(8'd0,   8'd0,   8'd0,   8'd0,   1'b0),  // negative R/B clamp to zero
      yuyv(8'd255, 8'd255, 8'd255, 8'd255, 1'b1),  // overflow saturates
      yuyv(8'd0,   8'd128, 8'd255, 8'd128, 1'b0),  // pure gray, both luma rails
      yuyv(8'd255, 8'd0,   8'd0,   8'd255, 1'b1),
      yuyv(8'd0,   8'd255, 8'd255, 8'd0,   1'b0),
      yuyv(8'd128, 8'd128, 8'd128, 8'd128, 1'b1),
      yuyv(8'd85,  8'd170, 8'd170, 8'd85,  1'b1),  // alternating bit patterns
      yuyv(8'd170, 8'd85,  8'd85,  8'd170, 1'b0),
      yuyv(8'd16,  8'd128, 8'd235, 8'd128, 1'b0),
      yuyv(8'd1,   8'd127, 8'd254, 8'd129, 1'b0),  // chroma one off neutral
      yuyv(8'd200, 8'd255, 8'd50,  8'd255, 1'b1),
      yuyv(8'd30,  8'd0,   8'd225, 8'd0,   1'b0)   // green pushed past 255
    };
    foreach (corners[i]) send_macropixel(corners[i]);
    // gain extremes, including values past unity that must saturate
    write_gain(9'd0);
    send_macropixel(yuyv(8'd255, 8'd128, 8'd255, 8'd128, 1'b0));
    write_gain(9'd1);
    send_macropixel(yuyv(8'd255, 8'd128, 8'd128, 8'd128, 1'b1));
    write_gain(9'd256);
    send_macropixel(yuyv(8'd255, 8'd128, 8'd254, 8'd128, 1'b0));
    write_gain(9'd257);
    send_macropixel(yuyv(8'd255, 8'd128, 8'd1,   8'd128, 1'b0));
    write_gain(9'd511);
    send_macropixel(yuyv(8'd255, 8'd128, 8'd128, 8'd128, 1'b1));
    send_macropixel(yuyv(8'd127, 8'd0,   8'd129, 8'd255, 1'b0));
  endtask

  // Random traffic at each extreme gain and at one random gain.
  task automatic test_gain_sweep();
    logic [8:0] sweep[$];
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    sweep = '{9'd0, 9'd1, 9'd255, 9'd256, 9'd257, 9'd511, random_gain()};
    foreach (sweep[i]) begin
      write_gain(sweep[i]);
      repeat (60) send_macropixel(random_macropixel($urandom_range(1, 0)));
    end
  endtask

  // Long random stream; each phase picks its own gain and idling mix,
  // so both full-rate stretches and gappy stretches occur.
  task automatic test_random_stream();
    for (int phase = 0; phase < 4; phase++) begin
      write_gain((phase == 0) ? GAIN_AT_RESET : random_gain());
      src_gaps  = phase[0];
      sink_gaps = phase[1];
      repeat (240) send_macropixel(random_macropixel($urandom_range(7, 0) == 0));
    end
  endtask

  // Frames of random length with the end mark only on the last macropixel.
  task automatic test_frame_marks();
    int unsigned len;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    write_gain(random_gain());
    repeat (24) begin
      len = $urandom_range(16, 1);
      for (int unsigned k = 1; k <= len; k++) send_macropixel(random_macropixel(k == len));
      frames_sent++;
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps pushing at
  // full rate: the pipe fills and in_stall has to back-pressure the source.
  task automatic test_back_pressure();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    drain_pipe();
    sink_hold = HOLD_CYCLES;
    repeat (60) send_macropixel(random_macropixel($urandom_range(1, 0)));
    sink_gaps = 1'b1;
    repeat (30) send_macropixel(random_macropixel($urandom_range(1, 0)));
  endtask

  // Short bursts with the sender pausing until every result is back.
  task automatic test_sender_pause();
    src_gaps  = 1'b0;
    sink_gaps = 1'b1;
    repeat (3) begin
      repeat (30) send_macropixel(random_macropixel($urandom_range(1, 0)));
      drain_pipe();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: draws a stall per result, honors a one-shot long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        stall_left = sink_gaps ? $urandom_range(MAX_WAIT, 0) : 0;
      end
      if (sink_hold != 0) begin
        stall_left = sink_hold;
        sink_hold  = 0;
      end
      @(negedge clk);
      out_stall = (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: each output transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rgb.size() == 0) begin
        $error("unexpected result transaction: %h", out_data);
        fail_count++;
      end else begin
        want = pending_rgb.pop_front();
        check_field("red_first",    want.red_first,    out_data.red_first);
        check_field("green_first",  want.green_first,  out_data.green_first);
        check_field("blue_first",   want.blue_first,   out_data.blue_first);
        check_field("red_second",   want.red_second,   out_data.red_second);
        check_field("green_second", want.green_second, out_data.green_second);
        check_field("blue_second",  want.blue_second,  out_data.blue_second);
        check_field("frame_last",   8'(want.frame_last), 8'(out_data.frame_last));
        rgb_checked++;
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction on either side means a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_rgb.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    gain_now         = GAIN_AT_RESET;
    src_gaps         = 1'b0;
    sink_gaps        = 1'b0;
    sink_hold        = 0;
    macropixels_sent = 0;
    rgb_checked      = 0;
    gains_applied    = 0;
    frames_sent      = 0;
    fail_count       = 0;
    quiet_cycles     = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed_corners();
    test_gain_sweep();
    test_random_stream();
    test_frame_marks();
    test_back_pressure();
    test_sender_pause();

    drain_pipe();
    repeat (PIPE_DEPTH * 4) @(negedge clk);
    if (pending_rgb.size() != 0) begin
      $error("%0d expected results never arrived", pending_rgb.size());
      fail_count++;
    end

    $display("Sent %0d macropixels (%0d framed groups), checked %0d RGB pairs",
             macropixels_sent, frames_sent, rgb_checked);
    $display("across %0d gain writes incl. 0, 1, 256, 257, 511 and a long back-pressure hold",
             gains_applied);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
